/* hw/rtl/sam_pkg.sv */
// ----------------------------------------------------------------------------
// sam_pkg: shared types and constants
// Record layout, cell control group and merge status group for the
// sort-and-merge block.
// ----------------------------------------------------------------------------
package sam_pkg;

  localparam int KEY_W = 32;
  localparam int LVL_W = 32;
  localparam int TOL_W = 16;

  // 0.001 in Q16.16, rounded to nearest
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic signed [LVL_W-1:0] level;
    logic                    mark;
  } rec_t;

  // shared control for every cell of the chain
  typedef struct packed {
    logic ins;   // insert broadcast record
    logic pop;   // shift toward the head
  } cell_ctrl_t;

  // status from the merge stage
  typedef struct packed {
    logic pop;   // head record consumed this cycle
    logic done;  // final result loaded, set complete
  } mrg_stat_t;

endpackage

/* hw/rtl/sam_if.sv */
// ----------------------------------------------------------------------------
// sam_in_if / sam_out_if: record and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sam_in_if
  import sam_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] key;
  logic signed [LVL_W-1:0] level;
  logic                    valid_mark;
  logic                    last_in;

  modport source (output valid, key, level, valid_mark, last_in, input ready);
  modport sink   (input valid, key, level, valid_mark, last_in, output ready);
endinterface

interface sam_out_if
  import sam_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] out_key;
  logic signed [LVL_W-1:0] out_level;
  logic                    out_mark;
  logic                    last_out;

  modport source (output valid, out_key, out_level, out_mark, last_out, input ready);
  modport sink   (input valid, out_key, out_level, out_mark, last_out, output ready);
endinterface

/* hw/rtl/sam_cell.sv */
// ----------------------------------------------------------------------------
// sam_cell: one slot of the insertion chain
// Holds one record. On insert it keeps, takes its left neighbor, or takes
// the new record; on pop it takes its right neighbor.
// ----------------------------------------------------------------------------
module sam_cell
  import sam_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  rec_t       new_rec,
  input  logic       occ,        // slot holds a record of the current set
  input  rec_t       left_rec,
  input  logic       left_gt,    // left neighbor moves right on insert
  input  rec_t       right_rec,
  output rec_t       rec,
  output logic       gt          // this slot moves right on insert
);

  rec_t rec_r;
  rec_t rec_nxt;

  // empty slots sort after everything; equal keys stay ahead of the new one
  assign gt = !occ || (rec_r.key > new_rec.key);

  always_comb begin
    rec_nxt = rec_r;
    if (ctrl.ins && gt) begin
      rec_nxt = left_gt ? left_rec : new_rec;
    end else if (ctrl.pop) begin
      rec_nxt = right_rec;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec = rec_r;

endmodule

/* hw/rtl/sam_merge.sv */
// ----------------------------------------------------------------------------
// sam_merge: run merge and output register
// Takes sorted records from the chain head, folds near keys into the open
// run and hands finished runs to the result channel.
// ----------------------------------------------------------------------------
module sam_merge
  import sam_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             drain,
  input  logic             head_avail,
  input  rec_t             head_rec,
  input  logic [TOL_W-1:0] tol,
  output mrg_stat_t        stat,
  sam_out_if.source        out_ch
);

  rec_t                    run_r,       run_nxt;
  logic                    run_vld_r,   run_vld_nxt;
  logic signed [KEY_W-1:0] prev_key_r,  prev_key_nxt;
  rec_t                    obuf_r,      obuf_nxt;
  logic                    olast_r,     olast_nxt;
  logic                    ovld_r,      ovld_nxt;

  logic                    step_ok;
  logic signed [KEY_W:0]   key_gap;
  logic                    near;

  // output slot free this cycle
  assign step_ok = !ovld_r || out_ch.ready;

  // sorted order: head key is never below the previous key
  assign key_gap = {head_rec.key[KEY_W-1], head_rec.key} - {prev_key_r[KEY_W-1], prev_key_r};
  assign near = run_vld_r && (key_gap <= $signed({{(KEY_W+1-TOL_W){1'b0}}, tol}));

  assign stat.pop  = drain && head_avail && step_ok;
  assign stat.done = drain && !head_avail && step_ok;

  always_comb begin
    run_nxt      = run_r;
    run_vld_nxt  = run_vld_r;
    prev_key_nxt = prev_key_r;
    obuf_nxt     = obuf_r;
    olast_nxt    = olast_r;
    ovld_nxt     = ovld_r && !out_ch.ready;
    if (stat.pop) begin
      prev_key_nxt = head_rec.key;
      if (near) begin
        if (head_rec.level > run_r.level) begin
          run_nxt.level = head_rec.level;
        end
      end else begin
        if (run_vld_r) begin
          obuf_nxt  = run_r;
          olast_nxt = 1'b0;
          ovld_nxt  = 1'b1;
        end
        run_nxt     = head_rec;
        run_vld_nxt = 1'b1;
      end
    end else if (stat.done) begin
      if (run_vld_r) begin
        obuf_nxt  = run_r;
        olast_nxt = 1'b1;
        ovld_nxt  = 1'b1;
      end
      run_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_vld_r <= 1'b0;
      ovld_r    <= 1'b0;
    end else begin
      run_vld_r <= run_vld_nxt;
      ovld_r    <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_r      <= run_nxt;
    prev_key_r <= prev_key_nxt;
    obuf_r     <= obuf_nxt;
    olast_r    <= olast_nxt;
  end

  assign out_ch.valid     = ovld_r;
  assign out_ch.out_key   = obuf_r.key;
  assign out_ch.out_level = obuf_r.level;
  assign out_ch.out_mark  = obuf_r.mark;
  assign out_ch.last_out  = olast_r;

endmodule

/* hw/rtl/sort_and_merge_near_keys_core.sv */
// ----------------------------------------------------------------------------
// sort_and_merge_near_keys_core: sort a record set, merge near keys
// Insertion cell chain followed by a run-merge output stage.
// ----------------------------------------------------------------------------
// Records are taken one per cycle while loading and placed in key order by a
// chain of ENTRIES insertion cells (equal keys keep arrival order); records
// past ENTRIES are dropped. The beat with last_in closes the set: input
// ready drops, and the chain shifts out through the merge stage one record
// per cycle while the output register is free, so a stall on the result
// channel holds the drain. Results stream in ascending key order; a
// record within the tolerance of its sorted predecessor folds into the
// current result, which keeps the larger level. Loading resumes the cycle
// after the final result is loaded. Write cfg_wdata only while idle.
module sort_and_merge_near_keys_core
  import sam_pkg::*;
#(
  parameter int ENTRIES = 64
)(
  input  logic             clk,
  input  logic             rst_n,
  sam_in_if.sink           in_ch,
  sam_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [TOL_W-1:0] cfg_wdata
);

  localparam int FILL_W = $clog2(ENTRIES + 1);

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic              state_r, state_nxt;
  logic [FILL_W-1:0] fill_r,  fill_nxt;
  logic [TOL_W-1:0]  tol_r;

  logic              in_acc;
  logic              room;
  cell_ctrl_t        ctrl;
  mrg_stat_t         mstat;
  rec_t              new_rec;
  rec_t              cell_rec [ENTRIES];
  logic [ENTRIES-1:0] cell_gt;
  logic [ENTRIES-1:0] occ;

  assign in_ch.ready = (state_r == ST_LOAD);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign room        = (fill_r < FILL_W'(ENTRIES));

  assign new_rec.key   = in_ch.key;
  assign new_rec.level = in_ch.level;
  assign new_rec.mark  = in_ch.valid_mark;

  assign ctrl.ins = in_acc && room;
  assign ctrl.pop = mstat.pop;

  // tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // load / drain sequencing and fill count
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    unique case (state_r)
      ST_LOAD: begin
        if (ctrl.ins) begin
          fill_nxt = fill_r + 1'b1;
        end
        if (in_acc && in_ch.last_in) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mstat.pop) begin
          fill_nxt = fill_r - 1'b1;
        end
        if (mstat.done) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

  // insertion chain, cell 0 is the head
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    rec_t left_rec;
    logic left_gt;
    rec_t right_rec;

    assign occ[g] = (FILL_W'(g) < fill_r);

    if (g == 0) begin : g_head
      assign left_rec = new_rec;
      assign left_gt  = 1'b0;
    end else begin : g_body
      assign left_rec = cell_rec[g-1];
      assign left_gt  = cell_gt[g-1];
    end

    if (g == ENTRIES - 1) begin : g_tail
      assign right_rec = cell_rec[g];
    end else begin : g_mid
      assign right_rec = cell_rec[g+1];
    end

    sam_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .new_rec   (new_rec),
      .occ       (occ[g]),
      .left_rec  (left_rec),
      .left_gt   (left_gt),
      .right_rec (right_rec),
      .rec       (cell_rec[g]),
      .gt        (cell_gt[g])
    );
  end

  // run merge and result register
  sam_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .drain      (state_r == ST_DRAIN),
    .head_avail (occ[0]),
    .head_rec   (cell_rec[0]),
    .tol        (tol_r),
    .stat       (mstat),
    .out_ch     (out_ch)
  );

endmodule

/* hw/rtl/sam_chk.sv */
// ----------------------------------------------------------------------------
// sam_chk: port-level checks for the sort-and-merge core
// Watches the record and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module sam_chk
  import sam_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_last,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [KEY_W-1:0] out_key,
  input logic signed [LVL_W-1:0] out_level,
  input logic                    out_last
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(out_level)
      && $stable(out_last))
    else $error("result beat changed while stalled");

  // closing beat stops loading
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input still open after closing beat");

  // a plain record keeps the block loading
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last |=> in_ready)
    else $error("input closed without closing beat");

  // only the final result of a set can wait while loading
  a_mid_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("non-final result seen while loading");

endmodule

bind sort_and_merge_near_keys_core sam_chk u_sam_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last_in),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_key   (out_ch.out_key),
  .out_level (out_ch.out_level),
  .out_last  (out_ch.last_out)
);

/* sim/sort_and_merge_near_keys_core_test.sv */
// ----------------------------------------------------------------------------
// sort_and_merge_near_keys_core_test: self-checking bench for the sort/merge core
// Streams record sets through the core and predicts every merged result. The
// prediction uses a stable insertion sort and a tolerance walk over the
// sorted set. Both channels stall at random. The tolerance changes between
// sets and covers zero, its largest value and values in between.
// ----------------------------------------------------------------------------
module sort_and_merge_near_keys_core_test;
  import sam_pkg::*;

  localparam int ENTRIES = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT = 8;

  typedef struct packed {
    rec_t rec;
    logic last;
  } result_t;

  // Predicts merged results from accepted record beats and checks them in order
  class merge_scoreboard;
    rec_t             held[ENTRIES];
    int unsigned      held_count;
    logic [TOL_W-1:0] tolerance;
    result_t          expected_q[$];
    int unsigned      errors;

    function new();
      held_count = 0;
      tolerance  = TOL_RESET;
      errors     = 0;
    endfunction

    function void note_record(rec_t r, logic closes);
      rec_t        run;
      rec_t        cur;
      int unsigned i;
      int unsigned j;
      longint      gap;
      // a full store drops the beat, but its last flag still closes the set
      if (held_count < ENTRIES) begin
        held[held_count] = r;
        held_count++;
      end
      if (!closes) return;
      // stable insertion sort by signed key
      for (i = 1; i < held_count; i++) begin
        cur = held[i];
        j = i;
        while (j > 0 && $signed(held[j-1].key) > $signed(cur.key)) begin
          held[j] = held[j-1];
          j--;
        end
        held[j] = cur;
      end
      // walk the sorted set; each key is compared with its direct predecessor
      run = held[0];
      for (i = 1; i < held_count; i++) begin
        gap = longint'($signed(held[i].key)) - longint'($signed(held[i-1].key));
        if (gap < 0) gap = -gap;
        if (gap <= longint'(tolerance)) begin
          if ($signed(held[i].level) > $signed(run.level)) run.level = held[i].level;
        end else begin
          expected_q.push_back('{run, 1'b0});
          run = held[i];
        end
      end
      expected_q.push_back('{run, 1'b1});
      held_count = 0;
    endfunction

    function void check_result(rec_t got, logic got_last);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: out_key %0d out_level %0d",
               $signed(got.key), $signed(got.level));
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.key !== want.rec.key) begin
        $error("out_key: expected %0d, got %0d", $signed(want.rec.key), $signed(got.key));
        errors++;
      end
      if (got.level !== want.rec.level) begin
        $error("out_level: expected %0d, got %0d",
               $signed(want.rec.level), $signed(got.level));
        errors++;
      end
      if (got.mark !== want.rec.mark) begin
        $error("out_mark: expected %0b, got %0b", want.rec.mark, got.mark);
        errors++;
      end
      if (got_last !== want.last) begin
        $error("last_out: expected %0b, got %0b", want.last, got_last);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [TOL_W-1:0] cfg_wdata;
  bit               no_stall;
  int unsigned      cycle_count = 0;
  merge_scoreboard  sorter_sb;

  sam_in_if  rec_bus ();
  sam_out_if res_bus ();

  sort_and_merge_near_keys_core #(
    .ENTRIES (ENTRIES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (rec_bus.sink),
    .out_ch    (res_bus.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk) begin
    res_bus.ready <= no_stall || ($urandom_range(99) >= 8);
  end

  // watch both channels; sampled before this edge's updates land
  always @(posedge clk) begin : beat_monitor
    rec_t seen;
    if (rst_n) begin
      if (rec_bus.valid && rec_bus.ready) begin
        seen.key   = rec_bus.key;
        seen.level = rec_bus.level;
        seen.mark  = rec_bus.valid_mark;
        sorter_sb.note_record(seen, rec_bus.last_in);
      end
      if (res_bus.valid && res_bus.ready) begin
        seen.key   = res_bus.out_key;
        seen.level = res_bus.out_level;
        seen.mark  = res_bus.out_mark;
        sorter_sb.check_result(seen, res_bus.last_out);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sort_and_merge_near_keys_core verification failed");
      $finish;
    end
  end

  // one record beat, with a random idle gap ahead of it
  task automatic send_record(rec_t r, logic closes);
    while (!no_stall && $urandom_range(99) < 8) begin
      rec_bus.valid <= 1'b0;
      @(posedge clk);
    end
    rec_bus.valid      <= 1'b1;
    rec_bus.key        <= r.key;
    rec_bus.level      <= r.level;
    rec_bus.valid_mark <= r.mark;
    rec_bus.last_in    <= closes;
    do @(posedge clk); while (!rec_bus.ready);
  endtask

  // directed record helper
  task automatic send_fields(logic [31:0] k, logic [31:0] l, logic m, logic closes);
    rec_t r;
    r.key   = k;
    r.level = l;
    r.mark  = m;
    send_record(r, closes);
  endtask

  // change tolerance once the core has drained; the first edge lets the
  // monitor note the closing beat before the queue is looked at
  task automatic write_tolerance(logic [TOL_W-1:0] value);
    rec_bus.valid <= 1'b0;
    @(posedge clk);
    while (sorter_sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sorter_sb.tolerance = value;
  endtask

  // a set of n records, keys mostly clustered so gaps sit near the tolerance, at times scattered at random
  task automatic send_set(int unsigned n, ref int unsigned sent);
    rec_t        r;
    logic [31:0] base;
    int unsigned spread;
    bit          scatter;
    base    = $urandom;
    spread  = (int'(sorter_sb.tolerance) + 1) * n;
    scatter = ($urandom_range(5) == 0);
    for (int unsigned k = 0; k < n; k++) begin
      r.key   = scatter ? $urandom : base + $urandom_range(spread);
      r.level = $urandom;
      r.mark  = $urandom_range(1);
      send_record(r, k == n - 1);
      sent++;
    end
  endtask

  // stimulus
  initial begin
    int unsigned sent;
    int unsigned phase_start;
    logic [TOL_W-1:0] tol_plan[6];

    sorter_sb = new();
    no_stall = 1'b0;
    sent = 0;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    rec_bus.valid      <= 1'b0;
    rec_bus.key        <= '0;
    rec_bus.level      <= '0;
    rec_bus.valid_mark <= 1'b0;
    rec_bus.last_in    <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset tolerance: lone record, then near chain, a gap of one past, extremes
    send_fields(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1);
    send_fields(32'd0,         32'd5,         1'b1, 1'b0);
    send_fields(32'd66,        32'd9,         1'b0, 1'b0);
    send_fields(32'd132,       -32'sd3,       1'b0, 1'b0);
    send_fields(32'd199,       32'd4,         1'b1, 1'b0);
    send_fields(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0);
    send_fields(32'h7FFF_FFFF, 32'd0,         1'b0, 1'b1);

    // zero tolerance: equal keys merge and keep the first arrival's mark
    write_tolerance('0);
    send_fields(32'd100,  32'd1,  1'b0, 1'b0);
    send_fields(32'd100,  32'd50, 1'b1, 1'b0);
    send_fields(-32'sd5,  32'd3,  1'b1, 1'b0);
    send_fields(32'd100,  32'd20, 1'b1, 1'b0);
    send_fields(32'd101,  32'd2,  1'b0, 1'b1);

    // widest tolerance: merge at the limit, split one past it
    write_tolerance('1);
    send_fields(32'd0,      32'd7,         1'b1, 1'b0);
    send_fields(32'd65535,  32'hFFFF_FFFF, 1'b0, 1'b0);
    send_fields(32'd131071, 32'd8,         1'b0, 1'b1);

    // random sets over several tolerance settings
    tol_plan = '{TOL_W'($urandom_range(65535)), 16'd1, TOL_RESET, 16'd300, 16'hFFFF, 16'd0};
    for (int p = 0; p < 6; p++) begin
      write_tolerance(tol_plan[p]);
      no_stall = (p == 1);
      phase_start = sent;
      // overfill the store once; the closing beat itself is dropped
      if (p == 2) send_set(ENTRIES + 3, sent);
      while (sent - phase_start < 28) send_set($urandom_range(1, 8), sent);
    end
    no_stall = 1'b0;
    rec_bus.valid <= 1'b0;
    @(posedge clk);

    while (sorter_sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sorter_sb.errors == 0 && sorter_sb.expected_q.size() == 0) begin
      $display("sort_and_merge_near_keys_core verification clean");
    end else begin
      $display("sort_and_merge_near_keys_core verification failed");
    end
    $finish;
  end

endmodule
